@@ rtl/rmct_pkg.sv @@
`default_nettype none

package rmct_pkg;

  localparam int unsigned VALUE_W    = 31;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned USED_RST   = 1024;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_FINAL = 5'b10000
  } state_e;

endpackage

`default_nettype wire

@@ rtl/rmct_ram.sv @@
`default_nettype none

module rmct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ rtl/range_max_count_tree.sv @@
// Load: busy while the new leaf's ancestors are rewritten up to the root, one tree level per cycle.
// Query: busy during the walk and its final merge; the walk issues two node reads per
//   level on the two RAM read ports. The result strobe shows when busy drops; an empty
//   range answers in the cycle after it is accepted, busy staying low. Loads give no result.
// Reset and every used_count write run a clearing pass over all 2*LEAVES RAM words (busy high).
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module range_max_count_tree #(
  parameter int unsigned LEAVES = rmct_pkg::LEAVES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         cmd_i,
  input  wire logic [rmct_pkg::VALUE_W-1:0] leaf_value_i,
  input  wire logic [rmct_pkg::CFG_W-1:0]   range_first_i,
  input  wire logic [rmct_pkg::CFG_W-1:0]   range_last_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [rmct_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                              result_strobe_o,
  output logic      [rmct_pkg::VALUE_W-1:0] max_value_o,
  output logic      [rmct_pkg::CFG_W-1:0]   max_count_o
);

  localparam int unsigned VW    = rmct_pkg::VALUE_W;
  localparam int unsigned CFW   = rmct_pkg::CFG_W;
  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = AW + 1;
  localparam int unsigned CW    = $clog2(LEAVES + 1);
  localparam int unsigned LW    = (CW > CFW) ? CW : CFW;
  localparam int unsigned DW    = VW + CW;

  typedef struct packed {
    logic [VW-1:0] m;
    logic [CW-1:0] c;
  } node_t;

  function automatic node_t merge(node_t a, node_t b);
    node_t res;
    res = a;
    if (a.m == b.m) begin
      res.c = a.c + b.c;
    end else if (b.m > a.m) begin
      res = b;
    end
    return res;
  endfunction

  rmct_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [CFW-1:0]   used_q, used_d;
  logic [AW-1:0]    idx_q, idx_d;
  node_t            acc_q, acc_d;
  logic [IW-1:0]    l_q, l_d;
  logic [IW-1:0]    r_q, r_d;
  node_t            lacc_q, lacc_d;
  node_t            racc_q, racc_d;
  logic             take_l_q, take_l_d;
  logic             take_r_q, take_r_d;
  logic             res_valid_q, res_valid_d;
  logic [VW-1:0]    max_value_q, max_value_d;
  logic [CFW-1:0]   max_count_q, max_count_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr_a;
  logic [AW-1:0] ram_raddr_b;
  logic [DW-1:0] ram_rdata_a;
  logic [DW-1:0] ram_rdata_b;

  logic [LW-1:0]      used_ext, leaves_lw, limit, pos_ext;
  logic [LW-1:0]      first_ext, last_ext, first_c, last_c;
  logic               load_ok, q_empty, accept;
  logic [AW-1:0]      leaf_addr, parent;
  logic [IW-1:0]      l_init, r_init, l_next, r_minus;
  logic               walk_live;
  node_t              rd_a, rd_b, merged_load, fin, leaf_node;
  logic [CW+CFW-1:0]  cnt_wide;

  rmct_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (ram_rdata_b)
  );

  assign busy   = (state_q != rmct_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign used_ext  = LW'(used_q);
  assign leaves_lw = LW'(LEAVES);
  assign limit     = (used_ext > leaves_lw) ? leaves_lw : used_ext;
  assign pos_ext   = LW'(pos_q);
  assign load_ok   = (pos_ext < limit);

  assign first_ext = LW'(range_first_i);
  assign last_ext  = LW'(range_last_i);
  assign first_c   = (first_ext == '0) ? LW'(1) : first_ext;
  assign last_c    = (last_ext > leaves_lw) ? leaves_lw : last_ext;
  assign q_empty   = (first_c > last_c);

  assign leaf_addr = AW'(LEAVES) + AW'(pos_q);
  assign leaf_node = '{m: leaf_value_i, c: CW'(1)};
  assign parent    = idx_q >> 1;

  assign l_init = IW'(first_c - LW'(1)) + IW'(LEAVES);
  assign r_init = IW'(last_c) + IW'(LEAVES);

  assign rd_a        = node_t'(ram_rdata_a);
  assign rd_b        = node_t'(ram_rdata_b);
  assign merged_load = merge(acc_q, rd_a);

  assign walk_live = (l_q < r_q);
  assign l_next    = (l_q + IW'(l_q[0])) >> 1;
  assign r_minus   = r_q - IW'(1);

  assign fin      = merge(lacc_q, racc_q);
  assign cnt_wide = {{CFW{1'b0}}, fin.c};

  // port A: sibling on the load path, left edge during the walk; port B: right edge
  always_comb begin
    case (state_q)
      rmct_pkg::ST_WALK: ram_raddr_a = l_q[AW-1:0];
      rmct_pkg::ST_LOAD: ram_raddr_a = parent ^ AW'(1);
      default:           ram_raddr_a = leaf_addr ^ AW'(1);
    endcase
    ram_raddr_b = r_minus[AW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    pos_d       = pos_q;
    used_d      = used_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    l_d         = l_q;
    r_d         = r_q;
    lacc_d      = lacc_q;
    racc_d      = racc_q;
    take_l_d    = 1'b0;
    take_r_d    = 1'b0;
    res_valid_d = 1'b0;
    max_value_d = max_value_q;
    max_count_d = max_count_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr_q;
    ram_wdata   = '0;

    case (state_q)
      rmct_pkg::ST_CLEAR: begin
        ram_we     = 1'b1;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = rmct_pkg::ST_IDLE;
        end
      end
      rmct_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_i == rmct_pkg::CMD_LOAD) begin
            // drop loads past the usable leaf count
            if (load_ok) begin
              ram_we    = 1'b1;
              ram_waddr = leaf_addr;
              ram_wdata = leaf_node;
              acc_d     = leaf_node;
              idx_d     = leaf_addr;
              pos_d     = pos_q + CW'(1);
              state_d   = rmct_pkg::ST_LOAD;
            end
          end else if (q_empty) begin
            res_valid_d = 1'b1;
            max_value_d = '0;
            max_count_d = '0;
          end else begin
            l_d     = l_init;
            r_d     = r_init;
            lacc_d  = '0;
            racc_d  = '0;
            state_d = rmct_pkg::ST_WALK;
          end
        end
      end
      rmct_pkg::ST_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = merged_load;
        acc_d     = merged_load;
        idx_d     = parent;
        if (parent == AW'(1)) begin
          state_d = rmct_pkg::ST_IDLE;
        end
      end
      rmct_pkg::ST_WALK: begin
        // fold in the nodes read last cycle, then advance both edges one level
        if (take_l_q) begin
          lacc_d = merge(lacc_q, rd_a);
        end
        if (take_r_q) begin
          racc_d = merge(racc_q, rd_b);
        end
        if (walk_live) begin
          take_l_d = l_q[0];
          take_r_d = r_q[0];
          l_d      = l_next;
          r_d      = r_q >> 1;
        end else begin
          state_d = rmct_pkg::ST_FINAL;
        end
      end
      rmct_pkg::ST_FINAL: begin
        res_valid_d = 1'b1;
        max_value_d = fin.m;
        max_count_d = cnt_wide[CFW-1:0];
        state_d     = rmct_pkg::ST_IDLE;
      end
      default: begin
        state_d = rmct_pkg::ST_CLEAR;
      end
    endcase

    // a new used_count restarts the tree
    if (cfg_we_i) begin
      used_d     = cfg_wdata_i;
      pos_d      = '0;
      clr_addr_d = '0;
      state_d    = rmct_pkg::ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmct_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      pos_q       <= '0;
      used_q      <= CFW'(rmct_pkg::USED_RST);
      take_l_q    <= 1'b0;
      take_r_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      pos_q       <= pos_d;
      used_q      <= used_d;
      take_l_q    <= take_l_d;
      take_r_q    <= take_r_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    acc_q       <= acc_d;
    l_q         <= l_d;
    r_q         <= r_d;
    lacc_q      <= lacc_d;
    racc_q      <= racc_d;
    max_value_q <= max_value_d;
    max_count_q <= max_count_d;
  end

  assign result_strobe_o = res_valid_q;
  assign max_value_o     = max_value_q;
  assign max_count_o     = max_count_q;

endmodule

`default_nettype wire

@@ tb/range_max_count_tree_tb.sv @@
`timescale 1ns / 100ps

module range_max_count_tree_tb;

  localparam int unsigned VALUE_W        = rmct_pkg::VALUE_W;
  localparam int unsigned CFG_W          = rmct_pkg::CFG_W;
  localparam logic        CMD_LOAD       = rmct_pkg::CMD_LOAD;
  localparam logic        CMD_QUERY      = rmct_pkg::CMD_QUERY;
  localparam int unsigned LEAVES         = rmct_pkg::LEAVES_DEF;
  localparam int unsigned LOAD_LATENCY   = $clog2(LEAVES) + 1;
  localparam int unsigned SETTLE_CYCLES  = LOAD_LATENCY + 4;
  localparam int unsigned DRAIN_CYCLES   = LOAD_LATENCY + 8;
  localparam int unsigned WATCHDOG_LIMIT = 8 * LEAVES + 1000;
  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned NUM_ROWS       = 27;

  typedef struct packed {
    logic [VALUE_W-1:0] mx;
    logic [31:0]        cnt;
  } span_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mx;
    logic [CFG_W-1:0]   cnt;
  } answer_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               cmd;
    logic [VALUE_W-1:0] value;
    logic [CFG_W-1:0]   first;
    logic [CFG_W-1:0]   last;
    logic [CFG_W-1:0]   cfg;
    logic               fixed;
    answer_t            fixed_ans;
  } row_t;

  // Directed sequence: empty tree after reset, clamps, empty ranges, loads past the
  // used count, zero-valued leaves, used_count of zero, one and above the leaf count.
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd1, 11'd1024, 11'd0, 1'b1, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd0, 11'd2047, 11'd0, 1'b1, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd7, 11'd3, 11'd0, 1'b1, '{31'd0, 11'd0}},
    '{ROW_CFG, CMD_LOAD, 31'd0, 11'd0, 11'd0, 11'd5, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'h7FFFFFFF, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'd0, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'h7FFFFFFF, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'd0, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'd1, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'd12345, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd1, 11'd5, 11'd0, 1'b1, '{31'h7FFFFFFF, 11'd2}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd2, 11'd2, 11'd0, 1'b1, '{31'd0, 11'd1}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd2, 11'd4, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd6, 11'd1024, 11'd0, 1'b1, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd0, 11'd0, 11'd0, 1'b1, '{31'd0, 11'd0}},
    '{ROW_CFG, CMD_LOAD, 31'd0, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'd99, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd1, 11'd1024, 11'd0, 1'b1, '{31'd0, 11'd0}},
    '{ROW_CFG, CMD_LOAD, 31'd0, 11'd0, 11'd0, 11'd2047, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'h55555555, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'h2AAAAAAA, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'h55555555, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd0, 11'd2047, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_CFG, CMD_LOAD, 31'd0, 11'd0, 11'd0, 11'd1, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'h2AAAAAAA, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_LOAD, 31'd7, 11'd0, 11'd0, 11'd0, 1'b0, '{31'd0, 11'd0}},
    '{ROW_ITEM, CMD_QUERY, 31'd0, 11'd1, 11'd1, 11'd0, 1'b1, '{31'h2AAAAAAA, 11'd1}}
  };

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic               cmd_i         = CMD_LOAD;
  logic [VALUE_W-1:0] leaf_value_i  = '0;
  logic [CFG_W-1:0]   range_first_i = '0;
  logic [CFG_W-1:0]   range_last_i  = '0;
  logic               cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i   = '0;
  logic               result_strobe_o;
  logic [VALUE_W-1:0] max_value_o;
  logic [CFG_W-1:0]   max_count_o;

  // Shadow tree and load pointer
  span_t            tree [2*LEAVES];
  int unsigned      next_leaf;
  logic [CFG_W-1:0] used_leaves;

  answer_t     pending_answers [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int          burst_left   = 0;

  range_max_count_tree #(
    .LEAVES(LEAVES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .leaf_value_i   (leaf_value_i),
    .range_first_i  (range_first_i),
    .range_last_i   (range_last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_strobe_o(result_strobe_o),
    .max_value_o    (max_value_o),
    .max_count_o    (max_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic span_t combine(input span_t a, input span_t b);
    span_t r;
    r = a;
    if (a.mx == b.mx) begin
      r.cnt = a.cnt + b.cnt;
    end else if (b.mx > a.mx) begin
      r = b;
    end
    return r;
  endfunction

  function automatic void tree_clear();
    foreach (tree[i]) tree[i] = '0;
    next_leaf = 0;
  endfunction

  function automatic int unsigned leaf_cap();
    return (used_leaves > LEAVES) ? LEAVES : used_leaves;
  endfunction

  // Returns 0 when the load is dropped because the used count is reached.
  function automatic bit tree_load(input logic [VALUE_W-1:0] value);
    int unsigned node;
    if (next_leaf >= leaf_cap()) return 1'b0;
    node = LEAVES + next_leaf;
    tree[node] = '{value, 32'd1};
    next_leaf++;
    for (node = node >> 1; node >= 1; node = node >> 1) begin
      tree[node] = combine(tree[2*node], tree[2*node+1]);
    end
    return 1'b1;
  endfunction

  function automatic answer_t tree_query(input logic [CFG_W-1:0] first_in,
                                         input logic [CFG_W-1:0] last_in);
    int unsigned lo, hi, l, r;
    span_t       acc_l, acc_r;
    answer_t     ans;
    lo = (first_in == 0) ? 1 : first_in;
    hi = (last_in > LEAVES) ? LEAVES : last_in;
    acc_l = '0;
    acc_r = '0;
    if (lo <= hi) begin
      l = lo - 1 + LEAVES;
      r = hi + LEAVES;
      while (l < r) begin
        if (l % 2 == 1) begin
          acc_l = combine(acc_l, tree[l]);
          l++;
        end
        if (r % 2 == 1) begin
          r--;
          acc_r = combine(acc_r, tree[r]);
        end
        l = l >> 1;
        r = r >> 1;
      end
      acc_l = combine(acc_l, acc_r);
    end
    ans.mx  = acc_l.mx;
    ans.cnt = acc_l.cnt[CFG_W-1:0];
    return ans;
  endfunction

  // Present one transaction and hold it until accepted. Start stays high on return;
  // the caller either issues the next transaction or drops start in this same step.
  task automatic issue(input logic op, input logic [VALUE_W-1:0] value,
                       input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] last,
                       input bit fixed, input answer_t fixed_ans, output bit effective);
    answer_t predicted;
    cmd_i         <= op;
    leaf_value_i  <= value;
    range_first_i <= first;
    range_last_i  <= last;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    effective = 1'b1;
    if (op == CMD_LOAD) begin
      effective = tree_load(value);
    end else begin
      predicted = tree_query(first, last);
      pending_answers.push_back(fixed ? fixed_ans : predicted);
    end
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Write only once every answer is in and the last load has had time to finish.
  task automatic write_used_count(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    used_leaves = value;
    tree_clear();
    // give the clearing pass time to raise busy
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : collect
    answer_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result: max_value %h max_count %0d", max_value_o, max_count_o);
        end
      end else begin
        want = pending_answers.pop_front();
        if (max_value_o !== want.mx || max_count_o !== want.cnt) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result mismatch: max_value exp %h got %h, max_count exp %0d got %0d",
                     want.mx, max_value_o, want.cnt, max_count_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && busy === 1'b0) || result_strobe_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("range_max_count_tree verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t               row;
    bit                 effective;
    int unsigned        random_items;
    int unsigned        phase_len;
    int unsigned        cap;
    int unsigned        pick;
    logic [VALUE_W-1:0] value;
    logic [CFG_W-1:0]   first;
    logic [CFG_W-1:0]   last;
    logic [CFG_W-1:0]   new_used;

    used_leaves = CFG_W'(rmct_pkg::USED_RST);
    tree_clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_used_count(row.cfg);
      end else begin
        issue(row.cmd, row.value, row.first, row.last, row.fixed, row.fixed_ans, effective);
        pace();
      end
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          new_used = CFG_W'($urandom_range(LEAVES + 1, 2047));
        end
        1: begin
          new_used = CFG_W'($urandom_range(65, LEAVES));
        end
        2: begin
          new_used = CFG_W'(LEAVES);
        end
        default: begin
          new_used = CFG_W'($urandom_range(1, 48));
        end
      endcase
      write_used_count(new_used);
      phase_len = $urandom_range(30, 90);
      for (int k = 0; k < phase_len; k++) begin
        cap = leaf_cap();
        if ((next_leaf < cap) ? ($urandom_range(0, 99) < 60) : ($urandom_range(0, 99) < 5)) begin
          // mostly small or near-maximum values so that ties show up in the counts
          case ($urandom_range(0, 3))
            0: value = VALUE_W'($urandom_range(0, 3));
            1: value = 31'h7FFFFFFF - VALUE_W'($urandom_range(0, 1));
            2: value = VALUE_W'($urandom());
            default: value = VALUE_W'($urandom_range(0, 15));
          endcase
          issue(CMD_LOAD, value, '0, '0, 1'b0, '0, effective);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            first = CFG_W'($urandom_range(0, 2047));
            last  = CFG_W'($urandom_range(0, 2047));
          end else if (pick < 20) begin
            first = CFG_W'($urandom_range(2, LEAVES));
            last  = CFG_W'($urandom_range(1, first - 1));
          end else begin
            first = CFG_W'($urandom_range(1, cap));
            last  = CFG_W'($urandom_range(first, cap));
          end
          issue(CMD_QUERY, VALUE_W'($urandom()), first, last, 1'b0, '0, effective);
        end
        if (effective) random_items++;
        pace();
      end
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("range_max_count_tree verification clean");
    end else begin
      $display("range_max_count_tree verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rmct_pkg.sv
rtl/rmct_ram.sv
rtl/range_max_count_tree.sv
tb/range_max_count_tree_tb.sv
